[hdl/mhdc2p_pkg.sv]
// ----------------------------------------------------------------------------
// mhdc2p_pkg
// Shared widths, constants and payload types of the MHD conserved-to-primitive
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mhdc2p_pkg;

	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned DENS_W     = DATA_WIDTH - 1;
	localparam int unsigned GAMMA_W    = 18;

	// squares and their sums
	localparam int unsigned SQ_W   = 2 * DATA_WIDTH;
	localparam int unsigned MAGT_W = SQ_W - FRAC_BITS - 1;

	// divider quotient widths
	localparam int unsigned VEL_QBITS = DATA_WIDTH;
	localparam int unsigned KE_QBITS  = DATA_WIDTH + FRAC_BITS + 1;
	localparam int unsigned KE_W      = KE_QBITS + 1;
	localparam int unsigned KDEN_W    = DENS_W + 1;

	// pressure datapath
	localparam int unsigned SAT_BIT   = DATA_WIDTH - 1 + FRAC_BITS;
	localparam int unsigned INNER_W   = KE_W + 2;
	localparam int unsigned PROD_W    = SAT_BIT + GAMMA_W;
	localparam int unsigned PRESS_LAT = 4;

	typedef logic signed [DATA_WIDTH-1:0] word_t;
	typedef logic [DATA_WIDTH-1:0]        uword_t;
	typedef logic [GAMMA_W-1:0]           gamma_t;

	localparam uword_t POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam uword_t NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	localparam gamma_t GAMMA_ONE   = gamma_t'(1 << FRAC_BITS);
	localparam gamma_t GAMMA_RESET = gamma_t'(109227);
	localparam gamma_t GM1_RESET   = GAMMA_RESET - GAMMA_ONE;

	typedef struct packed {
		logic [DENS_W-1:0] density;
		word_t             momentum_x;
		word_t             momentum_y;
		word_t             momentum_z;
		word_t             total_energy;
		word_t             field_x;
		word_t             field_y;
		word_t             field_z;
		logic              last_cell;
	} cell_in_t;

	typedef struct packed {
		logic [DENS_W-1:0] density_out;
		word_t             velocity_x;
		word_t             velocity_y;
		word_t             velocity_z;
		word_t             pressure;
		word_t             field_x_out;
		word_t             field_y_out;
		word_t             field_z_out;
		logic              last_cell_out;
		logic              bad_density;
	} prim_out_t;

	// gamma - 1 as sign and magnitude
	typedef struct packed {
		logic   neg;
		gamma_t mag;
	} gm1_t;

	typedef struct packed {
		word_t              energy;
		logic [MAGT_W-1:0]  mag_term;
		logic [KE_W-1:0]    ke;
	} press_in_t;

endpackage

`default_nettype wire

[hdl/mhdc2p_chan_if.sv]
// ----------------------------------------------------------------------------
// mhdc2p_chan_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhdc2p_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hdl/mhdc2p_div.sv]
// ----------------------------------------------------------------------------
// mhdc2p_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mhdc2p_div #(
	parameter int unsigned QW = 32,
	parameter int unsigned DW = 32
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [DW-1:0] rem_in,   // upper dividend part, below den_in
	input  wire logic [QW-1:0] num_in,   // dividend bits still to bring down
	input  wire logic [DW-1:0] den_in,
	output logic      [QW-1:0] quo_out
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] num_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_p;
		logic [DW-1:0] den_p;
		logic [QW-1:0] num_p;
		logic [QW-1:0] quo_p;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_p = rem_in;
			assign den_p = den_in;
			assign num_p = num_in;
			assign quo_p = '0;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign den_p = den_s[k-1];
			assign num_p = num_s[k-1];
			assign quo_p = quo_s[k-1];
		end

		assign trial = {rem_p, num_p[QW-1]};
		assign diff  = trial - {1'b0, den_p};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
				num_s[k] <= {num_p[QW-2:0], 1'b0};
				den_s[k] <= den_p;
				quo_s[k] <= {quo_p[QW-2:0], ge};
			end
		end
	end

	assign quo_out = quo_s[QW-1];

endmodule

`default_nettype wire

[hdl/mhdc2p_dly.sv]
// ----------------------------------------------------------------------------
// mhdc2p_dly
// Fixed-depth delay line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mhdc2p_dly #(
	parameter type         data_t = logic,
	parameter int unsigned DEPTH  = 1
) (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire data_t d,
	output data_t      q
);

	data_t line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

`default_nettype wire

[hdl/mhdc2p_press.sv]
// ----------------------------------------------------------------------------
// mhdc2p_press
// Four-stage pressure tail: internal energy, magnitude, scale by gamma-1,
// rounding and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module mhdc2p_press (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire mhdc2p_pkg::press_in_t pin,
	input  wire mhdc2p_pkg::gm1_t      gm1,
	output mhdc2p_pkg::word_t          pressure
);
	import mhdc2p_pkg::*;

	localparam logic [SAT_BIT:0] ROUND = (SAT_BIT+1)'((1 << FRAC_BITS) - 1);

	logic [INNER_W-1:0] inner_s1;

	logic               inner_neg;
	logic [INNER_W-1:0] a_full;
	logic [SAT_BIT-1:0] a_s2;
	logic               big_s2;
	logic               zero_s2;
	logic               neg_s2;

	logic [PROD_W-1:0]  prod_s3;
	logic               big_s3;
	logic               zero_s3;
	logic               neg_s3;

	logic               sat;
	logic [SAT_BIT:0]   rnd;
	uword_t             qmag;
	word_t              pressure_s4;

	// E - |B|^2/2 - |m|^2/(2 rho)
	always_ff @(posedge clk) begin
		if (en) begin
			inner_s1 <= INNER_W'(pin.energy) - INNER_W'(pin.mag_term) - INNER_W'(pin.ke);
		end
	end

	assign inner_neg = inner_s1[INNER_W-1];
	assign a_full    = inner_neg ? (~inner_s1 + 1'b1) : inner_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2    <= a_full[SAT_BIT-1:0];
			big_s2  <= |a_full[INNER_W-1:SAT_BIT];
			zero_s2 <= (a_full == '0) || (gm1.mag == '0);
			neg_s2  <= inner_neg ^ gm1.neg;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= PROD_W'(a_s2) * PROD_W'(gm1.mag);
			big_s3  <= big_s2;
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
		end
	end

	// negative results round the magnitude up, i.e. floor of the signed value
	assign sat  = big_s3 || (|prod_s3[PROD_W-1:SAT_BIT]);
	assign rnd  = {1'b0, prod_s3[SAT_BIT-1:0]} + ROUND;
	assign qmag = neg_s3 ? rnd[SAT_BIT:FRAC_BITS] : {1'b0, prod_s3[SAT_BIT-1:FRAC_BITS]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s3) begin
				pressure_s4 <= '0;
			end else if (sat) begin
				pressure_s4 <= neg_s3 ? NEG_MIN : POS_MAX;
			end else begin
				pressure_s4 <= neg_s3 ? (~qmag + 1'b1) : qmag;
			end
		end
	end

	assign pressure = pressure_s4;

endmodule

`default_nettype wire

[hdl/mhd_conserved_to_primitive.sv]
// ----------------------------------------------------------------------------
// mhd_conserved_to_primitive
// Ideal-MHD conserved-to-primitive conversion for a stream of grid cells.
// ----------------------------------------------------------------------------
// One request per clock in, one result per clock out while the result side
// does not stall. Every request passes three stages of magnitudes, squares
// and sums, then the 49-stage one-bit-per-stage divider that forms the kinetic
// term |m|^2/(2 rho), then four stages for the pressure. The velocity
// dividers (32 stages each) run in parallel, skewed to finish together with
// the kinetic divider. The result side has an output register plus one skid
// entry; the input stays ready until both hold a waiting result, so a stall
// of the result side freezes the pipeline without loss or repetition.
// Zero density raises bad_density and forces velocities and pressure to zero.
// Gamma is written through the cfg channel (always ready); gamma - 1 is
// precomputed at the write, so write it only while no cell is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module mhd_conserved_to_primitive (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mhdc2p_chan_if.sink         cell_in,
	mhdc2p_chan_if.source       prim_out,
	mhdc2p_chan_if.sink         cfg
);
	import mhdc2p_pkg::*;

	localparam int unsigned LAT      = 3 + KE_QBITS + PRESS_LAT;
	localparam int unsigned VEL_SKEW = KE_QBITS - VEL_QBITS;

	// fields that ride along untouched
	typedef struct packed {
		logic [DENS_W-1:0] density;
		word_t             field_x;
		word_t             field_y;
		word_t             field_z;
		word_t             energy;
		logic              last_cell;
	} pass_t;

	typedef struct packed {
		pass_t             pass;
		logic [MAGT_W-1:0] mag_term;
		logic [2:0]        vel_neg;
		logic [2:0]        vel_ovf;
		logic              ke_ovf;
		logic              bad;
	} side_t;

	typedef struct packed {
		logic [2:0][DENS_W-1:0]    rem;
		logic [2:0][VEL_QBITS-1:0] num;
		logic [DENS_W-1:0]         den;
	} vdiv_t;

	typedef struct packed {
		pass_t                      pass;
		logic [2:0][DATA_WIDTH-1:0] vel;
		logic                       bad;
	} post_t;

	function automatic uword_t mag_of(input uword_t v);
		mag_of = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic uword_t sat_vel(input logic neg, input logic ovf, input uword_t q);
		logic big;
		big = ovf || (neg ? (q > NEG_MIN) : (q > POS_MAX));
		if (big) begin
			sat_vel = neg ? NEG_MIN : POS_MAX;
		end else begin
			sat_vel = neg ? (~q + 1'b1) : q;
		end
	endfunction

	// ---------------- control ----------------
	logic           en;          // whole pipeline advances
	logic [LAT-1:0] vld_q;
	logic           push;
	logic           pop;
	logic           out_v_q;
	logic           skid_v_q;
	prim_out_t      out_q;
	prim_out_t      skid_q;
	prim_out_t      res;
	gm1_t           gm1_q;

	// ---------------- front stages ----------------
	logic [2:0][DATA_WIDTH-1:0] mom_in;
	logic [2:0][DATA_WIDTH-1:0] fld_in;

	pass_t                      pass_s1, pass_s2, pass_s3;
	logic [2:0][DATA_WIDTH-1:0] m_mag_s1, m_mag_s2, m_mag_s3;
	logic [2:0][DATA_WIDTH-1:0] b_mag_s1;
	logic [2:0]                 m_neg_s1, m_neg_s2, m_neg_s3;
	logic [2:0][SQ_W-1:0]       m_sq_s2, b_sq_s2;
	logic [SQ_W-1:0]            bsq;
	logic [SQ_W-1:0]            msq_s3;
	logic [MAGT_W-1:0]          magt_s3;

	// ---------------- divider side ----------------
	logic [KDEN_W-1:0]           den2;
	logic [KDEN_W-1:0]           ke_rem;
	side_t                       side_in, side_d;
	vdiv_t                       vdiv_in, vdiv_d;
	logic [KE_QBITS-1:0]         ke_quo;
	logic [2:0][VEL_QBITS-1:0]   vel_quo;
	press_in_t                   pin;
	post_t                       post_in, post_d;
	word_t                       press;

	assign en            = !skid_v_q;
	assign cell_in.ready = en;
	assign cfg.ready     = 1'b1;

	assign mom_in = {cell_in.payload.momentum_z, cell_in.payload.momentum_y,
		cell_in.payload.momentum_x};
	assign fld_in = {cell_in.payload.field_z, cell_in.payload.field_y,
		cell_in.payload.field_x};

	// s1: magnitudes, s2: squares, s3: sums of squares
	always_ff @(posedge clk) begin
		if (en) begin
			pass_s1.density   <= cell_in.payload.density;
			pass_s1.field_x   <= cell_in.payload.field_x;
			pass_s1.field_y   <= cell_in.payload.field_y;
			pass_s1.field_z   <= cell_in.payload.field_z;
			pass_s1.energy    <= cell_in.payload.total_energy;
			pass_s1.last_cell <= cell_in.payload.last_cell;
			for (int i = 0; i < 3; i++) begin
				m_neg_s1[i] <= mom_in[i][DATA_WIDTH-1];
				m_mag_s1[i] <= mag_of(mom_in[i]);
				b_mag_s1[i] <= mag_of(fld_in[i]);
			end

			pass_s2  <= pass_s1;
			m_mag_s2 <= m_mag_s1;
			m_neg_s2 <= m_neg_s1;
			for (int i = 0; i < 3; i++) begin
				m_sq_s2[i] <= SQ_W'(m_mag_s1[i]) * SQ_W'(m_mag_s1[i]);
				b_sq_s2[i] <= SQ_W'(b_mag_s1[i]) * SQ_W'(b_mag_s1[i]);
			end

			pass_s3  <= pass_s2;
			m_mag_s3 <= m_mag_s2;
			m_neg_s3 <= m_neg_s2;
			msq_s3   <= m_sq_s2[0] + m_sq_s2[1] + m_sq_s2[2];
			magt_s3  <= bsq[SQ_W-1:FRAC_BITS+1];
		end
	end

	assign bsq = b_sq_s2[0] + b_sq_s2[1] + b_sq_s2[2];

	// Kinetic term: quotient capped at 2^KE_QBITS. Any value that large
	// already drives the pressure into saturation, so the cap is exact.
	assign den2   = {pass_s3.density, 1'b0};
	assign ke_rem = KDEN_W'(msq_s3[SQ_W-1:KE_QBITS]);

	always_comb begin
		vdiv_in.den = pass_s3.density;
		for (int i = 0; i < 3; i++) begin
			// (|m| << FRAC_BITS) split into high part and bits to bring down
			vdiv_in.rem[i] = DENS_W'(m_mag_s3[i][DATA_WIDTH-1 -: FRAC_BITS]);
			vdiv_in.num[i] = {m_mag_s3[i][DATA_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
		end
	end

	always_comb begin
		side_in.pass     = pass_s3;
		side_in.mag_term = magt_s3;
		side_in.vel_neg  = m_neg_s3;
		side_in.ke_ovf   = ke_rem >= den2;
		side_in.bad      = pass_s3.density == '0;
		for (int i = 0; i < 3; i++) begin
			side_in.vel_ovf[i] = vdiv_in.rem[i] >= pass_s3.density;
		end
	end

	mhdc2p_div #(
		.QW (KE_QBITS),
		.DW (KDEN_W)
	) u_ke_div (
		.clk     (clk),
		.en      (en),
		.rem_in  (ke_rem),
		.num_in  (msq_s3[KE_QBITS-1:0]),
		.den_in  (den2),
		.quo_out (ke_quo)
	);

	mhdc2p_dly #(
		.data_t (side_t),
		.DEPTH  (KE_QBITS)
	) u_side_dly (
		.clk (clk),
		.en  (en),
		.d   (side_in),
		.q   (side_d)
	);

	// velocity dividers start late so all dividers finish in the same cycle
	mhdc2p_dly #(
		.data_t (vdiv_t),
		.DEPTH  (VEL_SKEW)
	) u_vel_skew (
		.clk (clk),
		.en  (en),
		.d   (vdiv_in),
		.q   (vdiv_d)
	);

	for (genvar i = 0; i < 3; i++) begin : g_vdiv
		mhdc2p_div #(
			.QW (VEL_QBITS),
			.DW (DENS_W)
		) u_div (
			.clk     (clk),
			.en      (en),
			.rem_in  (vdiv_d.rem[i]),
			.num_in  (vdiv_d.num[i]),
			.den_in  (vdiv_d.den),
			.quo_out (vel_quo[i])
		);
	end

	// ---------------- pressure tail ----------------
	always_comb begin
		pin.energy   = side_d.pass.energy;
		pin.mag_term = side_d.mag_term;
		pin.ke       = side_d.ke_ovf ? {1'b1, {KE_QBITS{1'b0}}} : {1'b0, ke_quo};

		post_in.pass = side_d.pass;
		post_in.bad  = side_d.bad;
		for (int i = 0; i < 3; i++) begin
			post_in.vel[i] = sat_vel(side_d.vel_neg[i], side_d.vel_ovf[i], vel_quo[i]);
		end
	end

	mhdc2p_press u_press (
		.clk      (clk),
		.en       (en),
		.pin      (pin),
		.gm1      (gm1_q),
		.pressure (press)
	);

	mhdc2p_dly #(
		.data_t (post_t),
		.DEPTH  (PRESS_LAT)
	) u_post_dly (
		.clk (clk),
		.en  (en),
		.d   (post_in),
		.q   (post_d)
	);

	always_comb begin
		res.density_out   = post_d.pass.density;
		res.velocity_x    = post_d.bad ? '0 : post_d.vel[0];
		res.velocity_y    = post_d.bad ? '0 : post_d.vel[1];
		res.velocity_z    = post_d.bad ? '0 : post_d.vel[2];
		res.pressure      = post_d.bad ? '0 : press;
		res.field_x_out   = post_d.pass.field_x;
		res.field_y_out   = post_d.pass.field_y;
		res.field_z_out   = post_d.pass.field_z;
		res.last_cell_out = post_d.pass.last_cell;
		res.bad_density   = post_d.bad;
	end

	// ---------------- output register and skid entry ----------------
	assign push = en && vld_q[LAT-1];
	assign pop  = out_v_q && prim_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[LAT-2:0], cell_in.valid};
			end
			if (pop || !out_v_q) begin
				out_v_q  <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign prim_out.valid   = out_v_q;
	assign prim_out.payload = out_q;

	// gamma - 1 kept as sign and magnitude for the pressure multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm1_q <= '{neg: 1'b0, mag: GM1_RESET};
		end else if (cfg.valid) begin
			gm1_q.neg <= cfg.payload < GAMMA_ONE;
			gm1_q.mag <= (cfg.payload < GAMMA_ONE) ? (GAMMA_ONE - cfg.payload)
				: (cfg.payload - GAMMA_ONE);
		end
	end

endmodule

`default_nettype wire
